// File: hw/rtl/coalescing_event_queue_macros.svh
// assertion macros shared by the coalescing event queue rtl
// no dependencies; files that assert include this header
`ifndef COALESCING_EVENT_QUEUE_MACROS_SVH
`define COALESCING_EVENT_QUEUE_MACROS_SVH

// same-cycle implication under an active-low reset
`define CEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under an active-low reset
`define CEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/ceq_pkg.sv
// package for the coalescing event queue: types, codes, reset constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ceq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int NUM_SLOTS       = 3;
	localparam int BYTE_W          = 8;
	localparam int COUNT_W         = 6;
	localparam int CFG_IDX_W       = 2;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [NUM_SLOTS-1:0][BYTE_W-1:0] id_vec_t;

	typedef enum logic [1:0] {
		ACT_QUERY = 2'd0,
		ACT_PUSH  = 2'd1,
		ACT_POP   = 2'd2
	} ceq_action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COAL_ID_A = 2'd0,
		REG_COAL_ID_B = 2'd1,
		REG_COAL_ID_C = 2'd2
	} ceq_reg_t;

	localparam byte_t COAL_ID_A_RST = 8'h20;
	localparam byte_t COAL_ID_B_RST = 8'h21;
	localparam byte_t COAL_ID_C_RST = 8'h22;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} ceq_state_t;

	// slot tracker update strobes for the executing transaction
	typedef struct packed {
		logic append;
		logic pop;
	} slot_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ceq_event_if.sv
// event input channel: valid/ready handshake with action, device id, value
// depends on ceq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ceq_event_if;
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	ceq_pkg::byte_t      device_id;
	ceq_pkg::byte_t      event_value;

	modport source (output valid, action, device_id, event_value, input ready);
	modport sink   (input valid, action, device_id, event_value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ceq_result_if.sv
// result output channel: valid/ready handshake with count, front entry, flags
// depends on ceq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ceq_result_if;
	logic                            valid;
	logic                            ready;
	logic [ceq_pkg::COUNT_W-1:0]     queued_count;
	logic                            front_valid;
	ceq_pkg::byte_t                  front_device;
	ceq_pkg::byte_t                  front_value;
	logic                            dropped;
	logic                            coalesced;

	modport source (output valid, queued_count, front_valid, front_device, front_value,
		dropped, coalesced, input ready);
	modport sink   (input valid, queued_count, front_valid, front_device, front_value,
		dropped, coalesced, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ceq_cfg_if.sv
// configuration write channel: valid/ready with register index and data
// depends on ceq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ceq_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ceq_pkg::CFG_IDX_W-1:0]     index;
	ceq_pkg::byte_t                    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ceq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ceq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ceq_slot_tracker.sv
// coalescing slots: per-id valid bit and store index, priority match logic
// depends on ceq_pkg and coalescing_event_queue_macros.svh
`timescale 1ns / 1ps
`default_nettype none

module ceq_slot_tracker #(
	parameter int IDX_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ceq_pkg::id_vec_t   coal_id,
	input  ceq_pkg::slot_ctl_t ctl,
	input  ceq_pkg::byte_t     dev,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [IDX_W-1:0]   rd_idx,
	output logic               hit,
	output logic [IDX_W-1:0]   hit_idx
);
	import ceq_pkg::*;

	`include "coalescing_event_queue_macros.svh"

	logic [NUM_SLOTS-1:0] valid_q;
	logic [IDX_W-1:0]     idx_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] set_sel;
	logic [NUM_SLOTS-1:0] clr_sel;
	logic                 set_found;
	logic                 clr_found;

	// first valid matching slot coalesces, first free matching slot claims,
	// first valid slot pointing at the front is released on pop
	always_comb begin
		hit       = 1'b0;
		hit_idx   = '0;
		set_sel   = '0;
		clr_sel   = '0;
		set_found = 1'b0;
		clr_found = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!hit && valid_q[k] && dev == coal_id[k]) begin
				hit     = 1'b1;
				hit_idx = idx_q[k];
			end
			if (!set_found && !valid_q[k] && dev == coal_id[k]) begin
				set_found  = 1'b1;
				set_sel[k] = 1'b1;
			end
			if (!clr_found && valid_q[k] && idx_q[k] == rd_idx) begin
				clr_found  = 1'b1;
				clr_sel[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int k = 0; k < NUM_SLOTS; k++) begin
				idx_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				if (ctl.append && set_sel[k]) begin
					valid_q[k] <= 1'b1;
					idx_q[k]   <= wr_idx;
				end else if (ctl.pop && clr_sel[k]) begin
					valid_q[k] <= 1'b0;
				end
			end
		end
	end

	`CEQ_ASSERT_IMP(a_slot_idx_unique, clk, arst_n, 1'b1,
		!(valid_q[0] && valid_q[1] && idx_q[0] == idx_q[1]) &&
		!(valid_q[0] && valid_q[2] && idx_q[0] == idx_q[2]) &&
		!(valid_q[1] && valid_q[2] && idx_q[1] == idx_q[2]),
		"two coalescing slots point at one store entry")
	`CEQ_ASSERT_IMP(a_append_no_hit, clk, arst_n, ctl.append, !hit,
		"append while a queued entry for the id exists")
	`CEQ_ASSERT_IMP(a_append_pop_excl, clk, arst_n, ctl.append, !ctl.pop,
		"append and pop in one transaction")

endmodule

`default_nettype wire

// File: hw/rtl/coalescing_event_queue.sv
// top level of the coalescing event queue: sequencer, ring pointers, config
// depends on ceq_pkg, the channel interfaces, ceq_ram, ceq_slot_tracker
//
// channel  | dir | payload                                            | handshake
// ---------+-----+----------------------------------------------------+----------
// evt      | in  | action, device_id, event_value                     | valid/ready
// res      | out | queued_count, front_valid, front_device,           | valid/ready
//          |     | front_value, dropped, coalesced                    |
// cfg      | in  | index, data (coalescing ids a, b, c)               | valid/ready
//
// each event passes through exec (read-modify-write of the store, pointer move)
// and resp (registered store read of the new front entry)
// the result sits in an output register, so the next event is taken as soon
// as that register can load; a stalled result holds the sequencer in its
// response state with the store read data held
// reset clears pointers, slots and the output valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module coalescing_event_queue #(
	parameter int QUEUE_DEPTH = ceq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ceq_event_if.sink  evt,
	ceq_result_if.source res,
	ceq_cfg_if.sink    cfg
);
	import ceq_pkg::*;

	`include "coalescing_event_queue_macros.svh"

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = AW + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CW = CW'(QUEUE_DEPTH);

	// ---------------------------------------------------------------
	// configuration registers; writes past the register list are ignored
	// ---------------------------------------------------------------
	id_vec_t coal_id_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coal_id_q[0] <= COAL_ID_A_RST;
			coal_id_q[1] <= COAL_ID_B_RST;
			coal_id_q[2] <= COAL_ID_C_RST;
		end else if (cfg.valid) begin
			case (ceq_reg_t'(cfg.index))
				REG_COAL_ID_A: coal_id_q[0] <= cfg.data;
				REG_COAL_ID_B: coal_id_q[1] <= cfg.data;
				REG_COAL_ID_C: coal_id_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// sequencer: idle -> exec (store access) -> resp (load result)
	// ---------------------------------------------------------------
	ceq_state_t state_q, state_d;
	logic       evt_ready;
	logic       evt_acc;
	logic       exec;
	logic       res_load;
	logic       res_valid_q;
	logic       load_ok;

	assign load_ok   = !res_valid_q || res.ready;
	assign evt.ready = evt_ready;
	assign evt_acc   = evt.valid && evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		evt_ready = 1'b0;
		exec      = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				exec    = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				// result leaves for the output register; next event may enter
				if (load_ok) begin
					res_load  = 1'b1;
					evt_ready = 1'b1;
					state_d   = evt.valid ? ST_EXEC : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// accepted event, held through exec and resp
	// ---------------------------------------------------------------
	ceq_action_t action_s1;
	byte_t       dev_s1;
	byte_t       val_s1;

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			action_s1 <= ceq_action_t'(evt.action);
			dev_s1    <= evt.device_id;
			val_s1    <= evt.event_value;
		end
	end

	// ---------------------------------------------------------------
	// ring pointers and the exec-cycle decisions
	// ---------------------------------------------------------------
	logic [AW-1:0] wr_q, rd_q;
	logic [AW-1:0] wr_next, rd_next;
	logic [AW-1:0] wr_new, rd_new;
	logic          hit;
	logic [AW-1:0] hit_idx;
	logic          is_push, full, do_coal, do_append, do_drop, do_pop;
	logic [CW-1:0] cnt_new;
	logic [31:0]   cnt_ext;
	slot_ctl_t     slot_ctl;

	assign wr_next = (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
	assign rd_next = (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);

	assign is_push   = exec && (action_s1 == ACT_PUSH);
	assign full      = (wr_next == rd_q);
	assign do_coal   = is_push && hit;
	assign do_append = is_push && !hit && !full;
	assign do_drop   = is_push && !hit && full;
	// a pop on an empty queue does nothing
	assign do_pop    = exec && (action_s1 == ACT_POP) && (wr_q != rd_q);

	assign wr_new = do_append ? wr_next : wr_q;
	assign rd_new = do_pop ? rd_next : rd_q;

	// occupancy after this event, reported modulo the count field width
	assign cnt_new = (wr_new >= rd_new) ? ({1'b0, wr_new} - {1'b0, rd_new})
		: ({1'b0, wr_new} + DEPTH_CW - {1'b0, rd_new});
	assign cnt_ext = 32'(cnt_new);

	assign slot_ctl.append = do_append;
	assign slot_ctl.pop    = do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			wr_q <= wr_new;
			rd_q <= rd_new;
		end
	end

	ceq_slot_tracker #(
		.IDX_W (AW)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.coal_id (coal_id_q),
		.ctl     (slot_ctl),
		.dev     (dev_s1),
		.wr_idx  (wr_q),
		.rd_idx  (rd_q),
		.hit     (hit),
		.hit_idx (hit_idx)
	);

	// ---------------------------------------------------------------
	// event store: device ids and values in two rams, so a coalesce
	// rewrites only the value byte
	// ---------------------------------------------------------------
	logic          val_we;
	logic [AW-1:0] val_waddr;
	byte_t         dev_rdata, val_rdata;

	assign val_we    = do_append || do_coal;
	assign val_waddr = do_coal ? hit_idx : wr_q;

	ceq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_dev_ram (
		.clk   (clk),
		.we    (do_append),
		.waddr (wr_q),
		.wdata (dev_s1),
		.re    (exec),
		.raddr (rd_new),
		.rdata (dev_rdata)
	);

	ceq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_s1),
		.re    (exec),
		.raddr (rd_new),
		.rdata (val_rdata)
	);

	// ---------------------------------------------------------------
	// exec -> resp: count, flags and forwarding marks for a write that
	// lands on the entry being read in the same cycle
	// ---------------------------------------------------------------
	logic [COUNT_W-1:0] cnt_s2;
	logic               nonempty_s2;
	logic               dropped_s2;
	logic               coalesced_s2;
	logic               fwd_dev_s2;
	logic               fwd_val_s2;

	always_ff @(posedge clk) begin
		if (exec) begin
			cnt_s2       <= cnt_ext[COUNT_W-1:0];
			nonempty_s2  <= (cnt_new != '0);
			dropped_s2   <= do_drop;
			coalesced_s2 <= do_coal;
			fwd_dev_s2   <= do_append && (wr_q == rd_new);
			fwd_val_s2   <= (do_append && (wr_q == rd_new)) ||
				(do_coal && (hit_idx == rd_new));
		end
	end

	// ---------------------------------------------------------------
	// output register; empty front reads as zeros
	// ---------------------------------------------------------------
	logic [COUNT_W-1:0] res_cnt_q;
	logic               res_fv_q;
	byte_t              res_dev_q;
	byte_t              res_val_q;
	logic               res_drop_q;
	logic               res_coal_q;
	byte_t              front_dev, front_val;

	assign front_dev = !nonempty_s2 ? '0 : (fwd_dev_s2 ? dev_s1 : dev_rdata);
	assign front_val = !nonempty_s2 ? '0 : (fwd_val_s2 ? val_s1 : val_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_cnt_q  <= cnt_s2;
			res_fv_q   <= nonempty_s2;
			res_dev_q  <= front_dev;
			res_val_q  <= front_val;
			res_drop_q <= dropped_s2;
			res_coal_q <= coalesced_s2;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.queued_count = res_cnt_q;
	assign res.front_valid  = res_fv_q;
	assign res.front_device = res_dev_q;
	assign res.front_value  = res_val_q;
	assign res.dropped      = res_drop_q;
	assign res.coalesced    = res_coal_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`CEQ_ASSERT_NXT(a_exec_to_resp, clk, arst_n, state_q == ST_EXEC, state_q == ST_RESP,
		"store access not followed by response cycle")
	`CEQ_ASSERT_IMP(a_flags_excl, clk, arst_n, res_load, !(dropped_s2 && coalesced_s2),
		"event both dropped and coalesced")
	`CEQ_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1,
		(wr_q <= LAST_IDX) && (rd_q <= LAST_IDX), "ring pointer beyond queue depth")

endmodule

`default_nettype wire
